>>> rtl/core/brse_pkg.sv
package brse_pkg;

    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(WORD_BITS);
    localparam int POS_W     = 5;
    localparam int LEN_W     = 6;
    localparam int ORG_W     = 12;
    localparam int SCALE_W   = 5;
    localparam int PROD_W    = LEN_W + SCALE_W;
    localparam int COORD_W   = 13;
    localparam int SPAN_W_W  = 10;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_PIXEL_SCALE = 2'd2;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_SCAN,
        SC_FLUSH
    } scan_state_t;

    typedef enum logic [1:0] {
        FM_IDLE,
        FM_X,
        FM_Y,
        FM_W
    } fmt_state_t;

    // raw span in icon units, handed from scanner to formatter
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] row;
        logic [LEN_W-1:0] len;
        logic             last;
    } span_raw_t;

    typedef struct packed {
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

endpackage

>>> rtl/core/brse_scan.sv
module brse_scan #(
    parameter int ROW_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [brse_pkg::WORD_BITS-1:0]   in_word,
    input  logic                             in_last,
    input  logic                             fmt_ready,
    output brse_pkg::span_raw_t              push
);

    localparam logic [brse_pkg::POS_W-1:0] LAST_COL = brse_pkg::POS_W'(ROW_WIDTH - 1);
    localparam logic [brse_pkg::IDX_W-1:0] LAST_IDX =
        brse_pkg::IDX_W'(brse_pkg::WORD_BITS - 1);

    brse_pkg::scan_state_t state_reg, state_next;

    logic [brse_pkg::IDX_W-1:0]     idx_reg;
    logic [brse_pkg::WORD_BITS-1:0] word_reg;
    logic                           last_reg;
    logic [brse_pkg::POS_W-1:0]     column_reg;
    logic [brse_pkg::POS_W-1:0]     row_reg;
    logic                           open_reg;
    logic [brse_pkg::POS_W-1:0]     start_reg;
    brse_pkg::span_raw_t            held_reg;

    logic                       bit_cur;
    logic                       at_end;
    logic                       found;
    logic [brse_pkg::POS_W-1:0] f_start;
    logic [brse_pkg::LEN_W-1:0] f_len;
    logic                       stall;
    logic                       advance;
    logic                       pushed;

    always_comb begin
        bit_cur = word_reg[idx_reg];
        at_end  = (column_reg >= LAST_COL);
        found   = 1'b0;
        f_start = start_reg;
        f_len   = '0;
        if (at_end) begin
            if (open_reg) begin
                found = 1'b1;
                f_len = {1'b0, column_reg - start_reg} + {{(brse_pkg::LEN_W-1){1'b0}}, bit_cur};
            end else if (bit_cur) begin
                found   = 1'b1;
                f_start = column_reg;
                f_len   = brse_pkg::LEN_W'(1);
            end
        end else if (!bit_cur && open_reg) begin
            found = 1'b1;
            f_len = {1'b0, column_reg - start_reg};
        end
        // a new span replaces the held one, which must go to the formatter first
        stall   = found && held_reg.valid && !fmt_ready;
        advance = (state_reg == brse_pkg::SC_SCAN) && !stall;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brse_pkg::SC_IDLE: begin
                if (in_valid) state_next = brse_pkg::SC_SCAN;
            end
            brse_pkg::SC_SCAN: begin
                if (advance && idx_reg == LAST_IDX) state_next = brse_pkg::SC_FLUSH;
            end
            brse_pkg::SC_FLUSH: begin
                if (!held_reg.valid || fmt_ready) state_next = brse_pkg::SC_IDLE;
            end
            default: state_next = brse_pkg::SC_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        push       = held_reg;
        push.valid = 1'b0;
        push.last  = 1'b0;
        case (state_reg)
            brse_pkg::SC_IDLE: begin
                in_ready = 1'b1;
            end
            brse_pkg::SC_SCAN: begin
                push.valid = advance && found && held_reg.valid;
            end
            brse_pkg::SC_FLUSH: begin
                // final span of the word carries the last flag
                push.valid = held_reg.valid;
                push.last  = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
        pushed = push.valid && fmt_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= brse_pkg::SC_IDLE;
            idx_reg        <= '0;
            last_reg       <= 1'b0;
            column_reg     <= '0;
            row_reg        <= '0;
            open_reg       <= 1'b0;
            start_reg      <= '0;
            held_reg.valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == brse_pkg::SC_IDLE && in_valid) begin
                idx_reg  <= '0;
                last_reg <= in_last;
            end
            if (advance) begin
                idx_reg <= idx_reg + brse_pkg::IDX_W'(1);
                if (found) begin
                    held_reg.valid <= 1'b1;
                    held_reg.start <= f_start;
                    held_reg.row   <= row_reg;
                    held_reg.len   <= f_len;
                    held_reg.last  <= 1'b0;
                end
                if (at_end) begin
                    column_reg <= '0;
                    row_reg    <= row_reg + brse_pkg::POS_W'(1);
                    open_reg   <= 1'b0;
                end else begin
                    if (bit_cur && !open_reg) begin
                        open_reg  <= 1'b1;
                        start_reg <= column_reg;
                    end else if (!bit_cur && open_reg) begin
                        open_reg <= 1'b0;
                    end
                    column_reg <= column_reg + brse_pkg::POS_W'(1);
                end
                // end of icon: position returns home, an open run is dropped
                if (idx_reg == LAST_IDX && last_reg) begin
                    column_reg <= '0;
                    row_reg    <= '0;
                    open_reg   <= 1'b0;
                    start_reg  <= '0;
                end
            end
            if (state_reg == brse_pkg::SC_FLUSH && pushed) begin
                held_reg.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == brse_pkg::SC_IDLE && in_valid) begin
            word_reg <= in_word;
        end
    end

endmodule

>>> rtl/core/brse_fmt.sv
module brse_fmt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  brse_pkg::cfg_t                    cfg,
    input  brse_pkg::span_raw_t               push,
    output logic                              ready,
    output logic                              out_valid,
    input  logic                              out_take,
    output logic [brse_pkg::COORD_W-1:0]      out_x,
    output logic [brse_pkg::COORD_W-1:0]      out_y,
    output logic [brse_pkg::SPAN_W_W-1:0]     out_w,
    output logic                              out_last
);

    brse_pkg::fmt_state_t state_reg, state_next;

    brse_pkg::span_raw_t              raw_reg;
    logic [brse_pkg::COORD_W-1:0]     x_reg;
    logic [brse_pkg::COORD_W-1:0]     y_reg;
    logic                             out_valid_reg;
    logic [brse_pkg::COORD_W-1:0]     out_x_reg;
    logic [brse_pkg::COORD_W-1:0]     out_y_reg;
    logic [brse_pkg::SPAN_W_W-1:0]    out_w_reg;
    logic                             out_last_reg;

    logic [brse_pkg::LEN_W-1:0]       mul_a;
    logic [brse_pkg::ORG_W-1:0]       add_b;
    logic [brse_pkg::PROD_W-1:0]      prod;
    logic [brse_pkg::COORD_W-1:0]     sum;

    // shared multiply-add: sum = a * scale + b
    always_comb begin
        prod = {{brse_pkg::SCALE_W{1'b0}}, mul_a} * {{brse_pkg::LEN_W{1'b0}}, cfg.scale};
        sum  = {{(brse_pkg::COORD_W-brse_pkg::PROD_W){1'b0}}, prod}
             + {1'b0, add_b};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brse_pkg::FM_IDLE: begin
                if (push.valid && ready) state_next = brse_pkg::FM_X;
            end
            brse_pkg::FM_X: state_next = brse_pkg::FM_Y;
            brse_pkg::FM_Y: state_next = brse_pkg::FM_W;
            brse_pkg::FM_W: state_next = brse_pkg::FM_IDLE;
            default:        state_next = brse_pkg::FM_IDLE;
        endcase
    end

    always_comb begin
        ready = 1'b0;
        mul_a = '0;
        add_b = '0;
        case (state_reg)
            brse_pkg::FM_IDLE: begin
                ready = !out_valid_reg;
            end
            brse_pkg::FM_X: begin
                mul_a = {1'b0, raw_reg.start};
                add_b = cfg.origin_x;
            end
            brse_pkg::FM_Y: begin
                mul_a = {1'b0, raw_reg.row};
                add_b = cfg.origin_y;
            end
            brse_pkg::FM_W: begin
                mul_a = raw_reg.len;
            end
            default: begin
                ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= brse_pkg::FM_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == brse_pkg::FM_W) begin
                out_valid_reg <= 1'b1;
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            brse_pkg::FM_IDLE: begin
                if (push.valid && ready) raw_reg <= push;
            end
            brse_pkg::FM_X: x_reg <= sum;
            brse_pkg::FM_Y: y_reg <= sum;
            brse_pkg::FM_W: begin
                out_x_reg    <= x_reg;
                out_y_reg    <= y_reg;
                out_w_reg    <= sum[brse_pkg::SPAN_W_W-1:0];
                out_last_reg <= raw_reg.last;
            end
            default: begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_w     = out_w_reg;
    assign out_last  = out_last_reg;

endmodule

>>> rtl/core/bitmap_row_span_extractor.sv
// Bitmap row span extractor: takes a one-bit-per-pixel icon as 32-bit words (bit 0 first,
// s_tlast on the icon's final word) and emits one item per run of set pixels, scaled to
// screen units from the origin_x / origin_y / pixel_scale registers; m_tlast marks the last
// span of each word. A word is scanned one pixel per cycle while the scan is not stalled, and
// the block accepts, scans and flushes one word before it takes the next. Each span then
// passes through a single multiply-add unit in turn for x, y and width, and one output
// register; when a new span is found while the last one still waits for the formatter, or
// the output is stalled, the pixel scan waits. s_tready is low while a word is being
// scanned.
module bitmap_row_span_extractor #(
    parameter int ROW_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pixel_word
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [12:0] span_x, [25:13] span_y, [35:26] span_width, zero pad
    output logic        m_tlast,   // last_of_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    brse_pkg::cfg_t      cfg_reg;
    brse_pkg::span_raw_t push;
    logic                fmt_ready;
    logic [1:0]          reg_idx;
    logic                cfg_wr;

    logic [brse_pkg::COORD_W-1:0]  span_x;
    logic [brse_pkg::COORD_W-1:0]  span_y;
    logic [brse_pkg::SPAN_W_W-1:0] span_width;

    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.scale    <= brse_pkg::SCALE_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                brse_pkg::REG_ORIGIN_X:    cfg_reg.origin_x <= pwdata[brse_pkg::ORG_W-1:0];
                brse_pkg::REG_ORIGIN_Y:    cfg_reg.origin_y <= pwdata[brse_pkg::ORG_W-1:0];
                brse_pkg::REG_PIXEL_SCALE: cfg_reg.scale    <= pwdata[brse_pkg::SCALE_W-1:0];
                default:                   cfg_reg.scale    <= cfg_reg.scale;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            brse_pkg::REG_ORIGIN_X:
                prdata = {{(32-brse_pkg::ORG_W){1'b0}}, cfg_reg.origin_x};
            brse_pkg::REG_ORIGIN_Y:
                prdata = {{(32-brse_pkg::ORG_W){1'b0}}, cfg_reg.origin_y};
            brse_pkg::REG_PIXEL_SCALE:
                prdata = {{(32-brse_pkg::SCALE_W){1'b0}}, cfg_reg.scale};
            default:
                prdata = '0;
        endcase
    end

    brse_scan #(
        .ROW_WIDTH(ROW_WIDTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .in_last   (s_tlast),
        .fmt_ready (fmt_ready),
        .push      (push)
    );

    brse_fmt u_fmt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .push      (push),
        .ready     (fmt_ready),
        .out_valid (m_tvalid),
        .out_take  (m_tready),
        .out_x     (span_x),
        .out_y     (span_y),
        .out_w     (span_width),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, span_width, span_y, span_x};

endmodule

>>> rtl/core/brse_check.sv
module brse_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // nothing is shown right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a word is scanned after it is accepted, so input closes after each accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready stayed high after an item was accepted");

    // each span is formatted in steps once the output is empty, no two back to back
    a_span_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("spans delivered in consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled span changed");

endmodule

bind bitmap_row_span_extractor brse_check u_check (.*);
